[rtl/lfust_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU slot table package
// Field widths, operation and register codes, and the compare unit's
// result type, shared by the table's modules.
// ----------------------------------------------------------------------------
package lfust_pkg;

  localparam int KEY_W      = 8;
  localparam int STAMP_W    = 32;
  localparam int SHOW_W     = 16;
  localparam int ACTIVE_W   = 5;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int REPORT_MAX = 16;
  localparam int REP_W      = 5;

  // Operation codes of a request.
  localparam logic OP_VOTE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Compare unit modes.
  localparam logic CMP_VICTIM = 1'b0;
  localparam logic CMP_REPORT = 1'b1;

  // Register word index taken from paddr[2].
  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RST = 5'd16;

  typedef struct packed {
    logic key_match;
    logic better;
  } cmp_res_t;

endpackage

[rtl/lfust_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfust_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lfust_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared slot compare unit
// Compares one scanned entry against the running best: victim order on a
// vote, next ascending key on a report, plus the key match for hits.
// ----------------------------------------------------------------------------
module lfust_cmp
  import lfust_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  mode,
  input  logic [KEY_W-1:0]      ent_key,
  input  logic [COUNT_BITS-1:0] ent_count,
  input  logic [STAMP_W-1:0]    ent_stamp,
  input  logic                  best_vld,
  input  logic [KEY_W-1:0]      best_key,
  input  logic [COUNT_BITS-1:0] best_count,
  input  logic [STAMP_W-1:0]    best_stamp,
  input  logic [KEY_W-1:0]      probe_key,
  input  logic                  first_pass,
  output cmp_res_t              res
);

  logic victim_less;
  logic above_floor;

  always_comb begin
    // Lowest count first, then oldest stamp, then smallest key.
    victim_less = {ent_count, ent_stamp, ent_key} < {best_count, best_stamp, best_key};
    above_floor = first_pass || (ent_key > probe_key);
    res.key_match = (ent_key == probe_key);
    case (mode)
      CMP_REPORT: res.better = above_floor && (!best_vld || (ent_key < best_key));
      default:    res.better = !best_vld || victim_less;
    endcase
  end

endmodule

[rtl/lfu_slot_table_oldest_tiebreak.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU slot table with oldest-first tie break
// Key table with use counts, least-frequently-used eviction and a sorted
// report of the resident keys.
// ----------------------------------------------------------------------------
// A request is either a vote for a key or a report of the resident keys. The
// table works on one request at a time and holds in_stall high until it has
// finished. Every request walks the slot memory one entry per cycle through a
// single compare unit. A vote's result is ready once its walk has ended, and
// the vote holds the table until that result is loaded into the output
// register. A report makes one such walk for each key it lists, up to 16,
// or a single walk when the table is empty. Each walk is paced by the
// memory's single read port. A finished result sits in the output register,
// so the next request can be taken while it waits for the consumer; a
// result that is still held by out_stall when the next one is ready holds
// the table until the register frees. Configuration is written through the
// APB port; the user must write it only while the table is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module lfu_slot_table_oldest_tiebreak
  import lfust_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [KEY_W-1:0]  key,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KEY_W-1:0]  out_key,
  output logic              hit,
  output logic              evicted,
  output logic [SHOW_W-1:0] vote_count,
  output logic              empty_res,
  output logic              last
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = ((OCC_W > REP_W) ? OCC_W : REP_W) + 1;
  localparam int ENT_W  = KEY_W + COUNT_BITS + STAMP_W;
  localparam int CW_EXT = (COUNT_BITS > SHOW_W) ? COUNT_BITS : SHOW_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_VDONE = 2'd2;
  localparam logic [1:0] S_RDONE = 2'd3;

  // Counts above the output width are shown saturated.
  function automatic logic [SHOW_W-1:0] show_count(input logic [COUNT_BITS-1:0] c);
    logic [CW_EXT-1:0] ext;
    ext = CW_EXT'(c);
    if (ext > CW_EXT'({SHOW_W{1'b1}})) begin
      return {SHOW_W{1'b1}};
    end
    return ext[SHOW_W-1:0];
  endfunction

  // Control state
  logic [1:0]          state;
  logic [ACTIVE_W-1:0] active_slots;
  logic [SLOTS-1:0]    slot_valid;
  logic [OCC_W-1:0]    occ;
  logic [STAMP_W-1:0]  vote_index;
  logic [IDX_W:0]      scan_idx;
  logic                pipe_vld;
  logic [IDX_W-1:0]    pipe_idx;
  logic                best_vld;
  logic                found;
  logic                free_vld;
  logic                rep_first;
  logic [REP_W-1:0]    rep_n;

  // Request and scan payload
  logic                  req_op;
  logic [KEY_W-1:0]      req_key;
  logic [IDX_W-1:0]      best_idx;
  logic [KEY_W-1:0]      best_key;
  logic [COUNT_BITS-1:0] best_count;
  logic [STAMP_W-1:0]    best_stamp;
  logic [IDX_W-1:0]      found_idx;
  logic [COUNT_BITS-1:0] found_count;
  logic [STAMP_W-1:0]    found_stamp;
  logic [IDX_W-1:0]      free_idx;
  logic [KEY_W-1:0]      rep_floor;

  // Memory and compare unit connections
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [ENT_W-1:0]      mem_rdata;
  logic [KEY_W-1:0]      ent_key;
  logic [COUNT_BITS-1:0] ent_count;
  logic [STAMP_W-1:0]    ent_stamp;
  logic                  cmp_mode;
  logic [KEY_W-1:0]      probe_key;
  cmp_res_t              cmp_res;

  // Derived per-request values
  logic                  out_free;
  logic                  out_load;
  logic                  cfg_write;
  logic                  ent_live;
  logic                  scan_end;
  logic [COUNT_BITS-1:0] count_next;
  logic [CMP_W-1:0]      eff;
  logic [CMP_W-1:0]      occ_ext;
  logic [CMP_W-1:0]      rep_total;
  logic                  rep_last;
  logic                  vote_evict;
  logic [IDX_W-1:0]      ins_idx;
  logic [SLOTS-1:0]      slot_valid_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SLOTS);
  assign prdata    = (paddr[2] == REG_ACTIVE_SLOTS) ? DATA_W'(active_slots) : '0;
  assign in_stall  = (state != S_IDLE);

  assign {ent_key, ent_count, ent_stamp} = mem_rdata;

  always_comb begin
    out_free  = !out_valid || !out_stall;
    out_load  = ((state == S_VDONE) || (state == S_RDONE)) && out_free;
    ent_live  = pipe_vld && slot_valid[pipe_idx];
    scan_end  = pipe_vld && (pipe_idx == IDX_W'(SLOTS - 1));
    cmp_mode  = (req_op == OP_REPORT) ? CMP_REPORT : CMP_VICTIM;
    probe_key = (req_op == OP_REPORT) ? rep_floor : req_key;

    count_next = (found_count == {COUNT_BITS{1'b1}}) ? found_count
                                                     : found_count + COUNT_BITS'(1);

    // A register value of zero acts as one, a value above SLOTS as SLOTS.
    if (active_slots == '0) begin
      eff = CMP_W'(1);
    end else if (CMP_W'(active_slots) > CMP_W'(SLOTS)) begin
      eff = CMP_W'(SLOTS);
    end else begin
      eff = CMP_W'(active_slots);
    end
    occ_ext    = CMP_W'(occ);
    vote_evict = (occ_ext >= eff) && best_vld;

    // The freed victim slot may be the lowest free slot after eviction.
    if (vote_evict && !(free_vld && (free_idx < best_idx))) begin
      ins_idx = best_idx;
    end else begin
      ins_idx = free_idx;
    end

    // Clear the victim first so that reusing its slot keeps it valid.
    slot_valid_next = slot_valid;
    if (vote_evict) begin
      slot_valid_next[best_idx] = 1'b0;
    end
    slot_valid_next[ins_idx] = 1'b1;

    rep_total = (occ_ext > CMP_W'(REPORT_MAX)) ? CMP_W'(REPORT_MAX) : occ_ext;
    rep_last  = (CMP_W'(rep_n) + CMP_W'(1)) == rep_total;

    mem_we = (state == S_VDONE) && out_free;
    if (found) begin
      mem_waddr = found_idx;
      mem_wdata = {req_key, count_next, found_stamp};
    end else begin
      mem_waddr = ins_idx;
      mem_wdata = {req_key, COUNT_BITS'(1), vote_index};
    end
  end

  lfust_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (mem_rdata)
  );

  lfust_cmp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cmp (
    .mode       (cmp_mode),
    .ent_key    (ent_key),
    .ent_count  (ent_count),
    .ent_stamp  (ent_stamp),
    .best_vld   (best_vld),
    .best_key   (best_key),
    .best_count (best_count),
    .best_stamp (best_stamp),
    .probe_key  (probe_key),
    .first_pass (rep_first),
    .res        (cmp_res)
  );

  // Payload registers: the request, the scan's running results and the
  // result fields carry no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_op  <= operation;
      req_key <= key;
    end
    if (state == S_SCAN) begin
      if (scan_idx < (IDX_W + 1)'(SLOTS)) begin
        pipe_idx <= scan_idx[IDX_W-1:0];
      end
      if (ent_live && cmp_res.better) begin
        best_idx   <= pipe_idx;
        best_key   <= ent_key;
        best_count <= ent_count;
        best_stamp <= ent_stamp;
      end
      if (ent_live && cmp_res.key_match && req_op == OP_VOTE) begin
        found_idx   <= pipe_idx;
        found_count <= ent_count;
        found_stamp <= ent_stamp;
      end
      if (pipe_vld && !slot_valid[pipe_idx] && !free_vld) begin
        free_idx <= pipe_idx;
      end
    end
    if (state == S_RDONE && out_free) begin
      rep_floor <= best_key;
    end
    if (state == S_VDONE && out_free) begin
      out_key    <= vote_evict && !found ? best_key : '0;
      hit        <= found;
      evicted    <= vote_evict && !found;
      vote_count <= found ? show_count(count_next) : SHOW_W'(1);
      empty_res  <= 1'b0;
      last       <= 1'b1;
    end
    if (state == S_RDONE && out_free) begin
      hit     <= 1'b0;
      evicted <= 1'b0;
      if (occ == '0) begin
        out_key    <= '0;
        vote_count <= '0;
        empty_res  <= 1'b1;
        last       <= 1'b1;
      end else begin
        out_key    <= best_key;
        vote_count <= show_count(best_count);
        empty_res  <= 1'b0;
        last       <= rep_last;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_slots <= ACTIVE_SLOTS_RST;
      slot_valid   <= '0;
      occ          <= '0;
      vote_index   <= '0;
      scan_idx     <= '0;
      pipe_vld     <= 1'b0;
      best_vld     <= 1'b0;
      found        <= 1'b0;
      free_vld     <= 1'b0;
      rep_first    <= 1'b1;
      rep_n        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        active_slots <= pwdata[ACTIVE_W-1:0];
      end
      // A new result loads the output register; otherwise a taken one leaves.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan_idx  <= '0;
            pipe_vld  <= 1'b0;
            best_vld  <= 1'b0;
            found     <= 1'b0;
            free_vld  <= 1'b0;
            rep_first <= 1'b1;
            rep_n     <= '0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          // One slot is read per cycle; its entry reaches the compare
          // unit through the memory's registered read data.
          if (scan_idx < (IDX_W + 1)'(SLOTS)) begin
            scan_idx <= scan_idx + (IDX_W + 1)'(1);
            pipe_vld <= 1'b1;
          end else begin
            pipe_vld <= 1'b0;
          end
          if (ent_live && cmp_res.better) begin
            best_vld <= 1'b1;
          end
          if (ent_live && cmp_res.key_match && req_op == OP_VOTE) begin
            found <= 1'b1;
          end
          if (pipe_vld && !slot_valid[pipe_idx]) begin
            free_vld <= 1'b1;
          end
          if (scan_end) begin
            state <= (req_op == OP_REPORT) ? S_RDONE : S_VDONE;
          end
        end

        S_VDONE: begin
          if (out_free) begin
            if (!found) begin
              if (!vote_evict) begin
                occ <= occ + OCC_W'(1);
              end
              slot_valid <= slot_valid_next;
            end
            if (vote_index != {STAMP_W{1'b1}}) begin
              vote_index <= vote_index + STAMP_W'(1);
            end
            state <= S_IDLE;
          end
        end

        S_RDONE: begin
          if (out_free) begin
            if (occ == '0 || rep_last) begin
              state <= S_IDLE;
            end else begin
              // Look for the next larger key on a fresh pass.
              rep_first <= 1'b0;
              rep_n     <= rep_n + REP_W'(1);
              scan_idx  <= '0;
              pipe_vld  <= 1'b0;
              best_vld  <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/lfu_slot_table_oldest_tiebreak_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU slot table testbench
// Drives votes and reports through the request channel, reprograms the
// active slot count through the APB port between phases, and checks every
// result against a behavioural model of the table held in a scoreboard.
// ----------------------------------------------------------------------------
module lfu_slot_table_oldest_tiebreak_tb;
  import lfust_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int USE_BITS    = 16;

  // One result as it appears on the result channel.
  typedef struct packed {
    logic [KEY_W-1:0]  out_key;
    logic              hit;
    logic              evicted;
    logic [SHOW_W-1:0] vote_count;
    logic              empty_res;
    logic              last;
  } table_result_t;

  // The scoreboard keeps its own copy of the table. Each accepted request is
  // played against it, and the results it would give are queued in order.
  class lfu_table_predictor;
    bit                   slot_used [TABLE_SLOTS];
    bit [KEY_W-1:0]       slot_key  [TABLE_SLOTS];
    longint unsigned      slot_uses [TABLE_SLOTS];
    bit [STAMP_W-1:0]     slot_stamp[TABLE_SLOTS];
    bit [STAMP_W-1:0]     vote_seq;
    bit [ACTIVE_W-1:0]    active_setting;
    table_result_t        pending_results[$];
    int unsigned          errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      vote_seq       = '0;
      active_setting = ACTIVE_SLOTS_RST;
      errors         = 0;
    endfunction

    function void set_active(logic [DATA_W-1:0] value);
      active_setting = value[ACTIVE_W-1:0];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Counts wider than the result field are shown as the field's maximum.
    function logic [SHOW_W-1:0] shown(longint unsigned uses);
      return (uses > 64'hFFFF) ? 16'hFFFF : uses[SHOW_W-1:0];
    endfunction

    function void note_request(logic req_op, logic [KEY_W-1:0] req_key);
      table_result_t   res;
      table_result_t   listing[$];
      int              eff;
      int              occupied;
      int              found;
      int              victim;
      int              target;
      longint unsigned use_max;
      res = '0;
      use_max = (64'd1 << USE_BITS) - 1;
      if (req_op == OP_REPORT) begin
        // Walk the key space upwards; only the first REPORT_MAX keys are listed.
        for (int k = 0; k < 256 && listing.size() < REPORT_MAX; k++) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i] && slot_key[i] == k[KEY_W-1:0]) begin
              res = '0;
              res.out_key    = k[KEY_W-1:0];
              res.vote_count = shown(slot_uses[i]);
              listing.push_back(res);
              break;
            end
          end
        end
        if (listing.size() == 0) begin
          res = '0;
          res.empty_res = 1'b1;
          res.last      = 1'b1;
          listing.push_back(res);
        end else begin
          listing[listing.size()-1].last = 1'b1;
        end
        foreach (listing[j]) pending_results.push_back(listing[j]);
        return;
      end

      eff = int'(active_setting);
      if (eff < 1) eff = 1;
      if (eff > TABLE_SLOTS) eff = TABLE_SLOTS;
      occupied = 0;
      found    = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_used[i]) begin
          occupied++;
          if (slot_key[i] == req_key) found = i;
        end
      end

      if (found >= 0) begin
        target  = found;
        res.hit = 1'b1;
        if (slot_uses[target] < use_max) slot_uses[target]++;
      end else begin
        // A miss on a full table (or one left oversized by a lowered setting)
        // frees exactly one entry: fewest uses, then oldest, then lowest key.
        if (occupied >= eff) begin
          victim = -1;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!slot_used[i]) continue;
            if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] &&
                 (slot_stamp[i] < slot_stamp[victim] ||
                  (slot_stamp[i] == slot_stamp[victim] &&
                   slot_key[i] < slot_key[victim]))))
              victim = i;
          end
          if (victim >= 0) begin
            slot_used[victim] = 1'b0;
            res.out_key = slot_key[victim];
            res.evicted = 1'b1;
          end
        end
        target = 0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
          if (!slot_used[i]) target = i;
        slot_used[target]  = 1'b1;
        slot_key[target]   = req_key;
        slot_uses[target]  = 1;
        slot_stamp[target] = vote_seq;
      end

      res.vote_count = shown(slot_uses[target]);
      res.last       = 1'b1;
      pending_results.push_back(res);
      if (vote_seq != 32'hFFFF_FFFF) vote_seq++;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key %0h count %0h",
                 $time, got.out_key, got.vote_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("out_key",    32'(want.out_key),    32'(got.out_key));
      check_field("hit",        32'(want.hit),        32'(got.hit));
      check_field("evicted",    32'(want.evicted),    32'(got.evicted));
      check_field("vote_count", 32'(want.vote_count), 32'(got.vote_count));
      check_field("empty_res",  32'(want.empty_res),  32'(got.empty_res));
      check_field("last",       32'(want.last),       32'(got.last));
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              operation = OP_VOTE;
  logic [KEY_W-1:0]  key       = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KEY_W-1:0]  out_key;
  logic              hit;
  logic              evicted;
  logic [SHOW_W-1:0] vote_count;
  logic              empty_res;
  logic              last;

  // When set, neither side inserts idle cycles, so requests run back to back.
  bit no_idle = 1'b0;

  lfu_table_predictor tally = new();

  always #1 clk = ~clk;

  lfu_slot_table_oldest_tiebreak dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_key    (out_key),
    .hit        (hit),
    .evicted    (evicted),
    .vote_count (vote_count),
    .empty_res  (empty_res),
    .last       (last)
  );

  // Presents one request after a random gap and holds it until the table
  // takes it. Every task here starts and ends just after a rising edge, and
  // in_valid stays high on return so that a following request with no gap
  // goes out without a bubble.
  task automatic send_request(logic req_op, logic [KEY_W-1:0] req_key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= req_op;
    key       <= req_key;
    do @(posedge clk); while (in_stall !== 1'b0);
    tally.note_request(req_op, req_key);
  endtask

  // Withdraws the request and waits until every predicted result has been
  // seen. Once the last result has been taken the table is idle again.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
  endtask

  // Setup and access phases of an APB write to the active slot register. The
  // register is only touched while the table is idle.
  task automatic write_active_slots(logic [DATA_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_SLOTS, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tally.set_active(value);
  endtask

  // A random phase draws most votes from a small pool of keys so that hits
  // and evictions are frequent, mixed with stray keys and reports. Halfway
  // through, the sender holds off until every result has come back.
  task automatic random_phase(logic [DATA_W-1:0] setting, int n_items, int pool_size);
    logic [KEY_W-1:0] pool[$];
    int               pick;
    write_active_slots(setting);
    for (int i = 0; i < pool_size; i++) pool.push_back(KEY_W'($urandom_range(0, 255)));
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_request(OP_REPORT, KEY_W'($urandom_range(0, 255)));
      else if (pick < 22)
        send_request(OP_VOTE, KEY_W'($urandom_range(0, 255)));
      else
        send_request(OP_VOTE, pool[$urandom_range(0, pool.size() - 1)]);
    end
  endtask

  // Result side: stalls for a random number of cycles before each result,
  // then takes it and hands it to the scoreboard.
  initial begin : result_sink
    int            hold;
    table_result_t got;
    @(negedge rst);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 9);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.out_key    = out_key;
      got.hit        = hit;
      got.evicted    = evicted;
      got.vote_count = vote_count;
      got.empty_res  = empty_res;
      got.last       = last;
      tally.check_result(got);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset setting: a report of the empty table, the
    // lowest and highest keys, a hit, and a short listing.
    send_request(OP_REPORT, 8'h00);
    send_request(OP_VOTE, 8'h00);
    send_request(OP_VOTE, 8'hFF);
    send_request(OP_VOTE, 8'hFF);
    send_request(OP_REPORT, 8'hFF);

    // A setting of zero behaves as one. The table now holds more entries
    // than that, so the next miss frees exactly one entry and reuses it.
    write_active_slots(32'd0);
    send_request(OP_VOTE, 8'hAA);
    send_request(OP_VOTE, 8'hAA);
    send_request(OP_REPORT, 8'h00);

    // The largest setting acts as the full table. Fill every slot, force an
    // eviction among equal counts (the oldest entry must go), then list all
    // sixteen residents.
    write_active_slots(32'd31);
    for (int i = 0; i < 15; i++) send_request(OP_VOTE, KEY_W'(8'h10 + i * 8'h11));
    send_request(OP_VOTE, 8'h77);
    send_request(OP_REPORT, 8'h00);

    // Random phases across a spread of settings, including the extremes, a
    // value with stray upper bits and one left to chance.
    random_phase(32'd16, 30, 20);
    random_phase(32'd1, 20, 3);
    no_idle = 1'b1;
    random_phase(32'd5, 25, 8);
    no_idle = 1'b0;
    random_phase(32'hFFFF_FFE3, 20, 5);
    random_phase(32'd0, 15, 3);
    random_phase(32'd24, 30, 24);
    random_phase(DATA_W'($urandom_range(0, 31)), 20, $urandom_range(2, 24));

    // Wait for the last results, then allow a report's worth of cycles for
    // anything unexpected to surface.
    drain_results();
    repeat (300) @(posedge clk);
    if (tally.errors == 0)
      $display("lfu_slot_table_oldest_tiebreak test passed");
    else
      $display("lfu_slot_table_oldest_tiebreak test failed");
    $finish;
  end

  // Safety net in case the table hangs: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("lfu_slot_table_oldest_tiebreak test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/lfust_pkg.sv
rtl/lfust_mem.sv
rtl/lfust_cmp.sv
rtl/lfu_slot_table_oldest_tiebreak.sv
bench/lfu_slot_table_oldest_tiebreak_tb.sv
